[src/assert_macros.svh]
// Assertion macros for the top-level RTL file of the scaled modular exponentiation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is ignored while reset is asserted
`define SMX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define SMX_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/smx_pkg.sv]
// Shared constants and controller/datapath types for the scaled modular exponentiation unit.
package smx_pkg;

    localparam int MOD_BITS = 31;
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(MOD_BITS);

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(64'd2147483647);
    localparam logic [CNT_W-1:0]    CNT_MAX       = CNT_W'(MOD_BITS - 1);

    // What the shared multiply lanes are doing
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_EXP,
        OP_FINAL
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic             last;
        t_op              op;
        logic [CNT_W-1:0] bit_idx;
        logic             out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                exp_any;
        logic                exp_more;
        logic                mod_small;
        logic [MOD_BITS-1:0] modulus;
    } t_status;

endpackage

[src/smx_if.sv]
// Handshake channel interfaces: input word, result word and modulus write.
interface smx_in_if;
    import smx_pkg::*;
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] base_value;
    logic [EXP_BITS-1:0] exponent_value;
    logic [MOD_BITS-1:0] scale_factor;

    modport source (output valid, base_value, exponent_value, scale_factor, input ready);
    modport sink   (input valid, base_value, exponent_value, scale_factor, output ready);
endinterface

interface smx_out_if;
    import smx_pkg::*;
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

interface smx_cfg_if;
    import smx_pkg::*;
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/smx_datapath.sv]
// Datapath: modulus register, operand registers and two bit-serial modular multiply lanes.
module smx_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smx_pkg::t_cmd                 i_cmd,
    output smx_pkg::t_status              o_status,
    input  logic                          i_cfg_valid,
    input  logic [smx_pkg::MOD_BITS-1:0]  i_cfg_data,
    input  logic [smx_pkg::MOD_BITS-1:0]  i_base,
    input  logic [smx_pkg::EXP_BITS-1:0]  i_exp,
    input  logic [smx_pkg::MOD_BITS-1:0]  i_scale,
    output logic [smx_pkg::MOD_BITS-1:0]  o_result
);
    import smx_pkg::*;

    // Shift-and-add step: p = 2p (+ybit if reducing), then + x if multiplying and ybit
    function automatic logic [MOD_BITS-1:0] lane_step(
        input logic [MOD_BITS-1:0] p,
        input logic [MOD_BITS-1:0] x,
        input logic                ybit,
        input logic                red,
        input logic [MOD_BITS-1:0] m
    );
        logic [MOD_BITS:0] t1;
        logic [MOD_BITS:0] t2;
        logic [MOD_BITS:0] t3;
        logic [MOD_BITS:0] t4;
        logic [MOD_BITS:0] mw;
        begin
            mw = {1'b0, m};
            t1 = {p, red & ybit};
            t2 = (t1 >= mw) ? t1 - mw : t1;
            t3 = (!red && ybit) ? t2 + {1'b0, x} : t2;
            t4 = (t3 >= mw) ? t3 - mw : t3;
            return t4[MOD_BITS-1:0];
        end
    endfunction

    logic [MOD_BITS-1:0] r_modulus;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_sq;
    logic [MOD_BITS-1:0] r_scl;
    logic [EXP_BITS-1:0] r_exp;
    logic [MOD_BITS-1:0] r_pa;
    logic [MOD_BITS-1:0] r_pb;
    logic [MOD_BITS-1:0] r_result;

    logic [MOD_BITS-1:0] n_pa;
    logic [MOD_BITS-1:0] n_pb;
    logic [MOD_BITS-1:0] w_xa;
    logic                w_ya;
    logic                w_red;
    logic                w_mod_small;

    assign w_mod_small = (r_modulus < MOD_BITS'(2));

    // Lane A: scale reduction, acc*sq, final scale*acc. Lane B: base reduction, sq*sq.
    always_comb begin
        w_red = 1'b0;
        w_xa  = r_acc;
        w_ya  = r_sq[i_cmd.bit_idx];
        case (i_cmd.op)
            OP_REDUCE: begin
                w_red = 1'b1;
                w_ya  = r_scl[i_cmd.bit_idx];
            end
            OP_EXP: begin
                w_xa = r_acc;
                w_ya = r_sq[i_cmd.bit_idx];
            end
            OP_FINAL: begin
                w_xa = r_scl;
                w_ya = r_acc[i_cmd.bit_idx];
            end
            default: begin
                w_red = 1'b0;
            end
        endcase
        n_pa = lane_step(r_pa, w_xa, w_ya, w_red, r_modulus);
        n_pb = lane_step(r_pb, r_sq, r_sq[i_cmd.bit_idx], w_red, r_modulus);
    end

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET;
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_data;
        end
    end

    // Operand and partial product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq  <= i_base;
            r_scl <= i_scale;
            r_exp <= i_exp;
            r_acc <= MOD_BITS'(1);
            r_pa  <= '0;
            r_pb  <= '0;
        end else if (i_cmd.step) begin
            if (i_cmd.last) begin
                r_pa <= '0;
                r_pb <= '0;
                case (i_cmd.op)
                    OP_REDUCE: begin
                        r_scl <= n_pa;
                        r_sq  <= n_pb;
                    end
                    OP_EXP: begin
                        if (r_exp[0]) begin
                            r_acc <= n_pa;
                        end
                        r_sq  <= n_pb;
                        r_exp <= r_exp >> 1;
                    end
                    OP_FINAL: begin
                        r_acc <= n_pa;
                    end
                    default: begin
                        r_acc <= r_acc;
                    end
                endcase
            end else begin
                r_pa <= n_pa;
                r_pb <= n_pb;
            end
        end
        if (i_cmd.out_load) begin
            r_result <= w_mod_small ? '0 : r_acc;
        end
    end

    assign o_status.exp_any   = (r_exp != '0);
    assign o_status.exp_more  = ((r_exp >> 1) != '0);
    assign o_status.mod_small = w_mod_small;
    assign o_status.modulus   = r_modulus;
    assign o_result           = r_result;

endmodule

[src/smx_ctrl.sv]
// Controller: sequences reduction, exponent bit steps and final scaling, owns the result valid.
module smx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  smx_pkg::t_status i_status,
    output smx_pkg::t_cmd    o_cmd
);
    import smx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_EXP,
        S_FIN,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    // Commands decoded from state
    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step     = r_state inside {S_RED, S_EXP, S_FIN};
        o_cmd.last     = (r_cnt == '0);
        o_cmd.bit_idx  = r_cnt;
        o_cmd.out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
        case (r_state)
            S_EXP:   o_cmd.op = OP_EXP;
            S_FIN:   o_cmd.op = OP_FINAL;
            default: o_cmd.op = OP_REDUCE;
        endcase
    end

    // State, bit counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // New result word replaces a taken one in the same cycle
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RED;
                        r_cnt   <= CNT_MAX;
                    end
                end
                S_RED, S_EXP, S_FIN: begin
                    if (r_cnt == '0) begin
                        r_cnt <= CNT_MAX;
                        if (r_state == S_RED) begin
                            r_state <= i_status.exp_any ? S_EXP : S_FIN;
                        end else if (r_state == S_EXP) begin
                            r_state <= i_status.exp_more ? S_EXP : S_FIN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_OUT: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[src/scaled_modular_exponentiation_unit.sv]
// Scaled modular exponentiation unit: (scale * base^exp) mod modulus, one word at a time.
// Each input word yields one result word using two bit-serial modular multiply lanes:
// first they reduce base and scale, then they take one pass per exponent bit up to the
// highest set bit (multiply and square run side by side), then one pass for the final
// scaling, after which the result register is loaded. A new word is accepted once the
// previous one has moved into the result register. The modulus is to be written through
// the configuration channel between words; the block itself does not enforce this. A
// modulus of 0 or 1 gives 0.
module scaled_modular_exponentiation_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smx_in_if.sink    i_in,
    smx_out_if.source o_res,
    smx_cfg_if.sink   i_cfg
);
    import smx_pkg::*;
    `include "assert_macros.svh"

    t_cmd    w_cmd;
    t_status w_status;

    assign i_cfg.ready = 1'b1;

    smx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    smx_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_base      (i_in.base_value),
        .i_exp       (i_in.exponent_value),
        .i_scale     (i_in.scale_factor),
        .o_result    (o_res.result_value)
    );

    // Checks
    `SMX_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready |=> !i_in.ready, "input accepted while a word is in work")
    `SMX_ASSERT(a_result_reduced, i_clk, i_rst_n, o_res.valid && !w_status.mod_small |-> o_res.result_value < w_status.modulus, "result not reduced below modulus")
    `SMX_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !o_res.valid, "result valid after reset")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the scaled modular exponentiation unit.
module tb_top;
    import smx_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int PHASE_WORDS = 60;
    localparam int RANDOM_PHASES = 9;
    localparam logic [MOD_BITS-1:0] MOD_TOP = {MOD_BITS{1'b1}};

    // Receiver behavior for one stall window
    typedef enum logic [1:0] {
        RDY_OPEN,
        RDY_PATTERN,
        RDY_HOLD
    } t_rdy_mode;

    typedef struct packed {
        logic [MOD_BITS-1:0] base;
        logic [EXP_BITS-1:0] expo;
        logic [MOD_BITS-1:0] scale;
    } t_operand;

    logic i_clk;
    logic i_rst_n;

    smx_in_if  in_ch ();
    smx_out_if res_ch ();
    smx_cfg_if cfg_ch ();

    scaled_modular_exponentiation_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    t_operand            operand_q[$];
    logic [MOD_BITS-1:0] power_q[$];
    logic [MOD_BITS-1:0] modulus_now = MODULUS_RESET;
    logic [MOD_BITS-1:0] want;
    t_operand            cur;
    int                  in_sent = 0;
    int                  in_taken = 0;
    int                  err_cnt = 0;
    int                  cycle_cnt = 0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    int                  stall_cnt = 0;
    logic [31:0]         stall_pat = '0;
    t_rdy_mode           stall_mode = RDY_OPEN;

    // Exact value of (scale * base^expo) mod m; m below two gives zero
    function automatic logic [MOD_BITS-1:0] scaled_power(t_operand op, logic [MOD_BITS-1:0] m);
        longint unsigned mm;
        longint unsigned sq;
        longint unsigned acc;
        if (m < 2) return '0;
        mm  = m;
        sq  = op.base % mm;
        acc = 1;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (op.expo[i]) acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        acc = ((op.scale % mm) * acc) % mm;
        return acc[MOD_BITS-1:0];
    endfunction

    // 31-bit operand: edge values, small, unreduced near or at multiples of the modulus, or fully random
    function automatic logic [MOD_BITS-1:0] pick_residue(logic [MOD_BITS-1:0] m);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MOD_TOP;
            2: return MOD_BITS'($urandom_range(0, 20));
            3: return m + MOD_BITS'($urandom_range(0, 5));
            4: return m * MOD_BITS'($urandom_range(1, 9));
            default: return MOD_BITS'($urandom());
        endcase
    endfunction

    function automatic t_operand rand_operand(logic [MOD_BITS-1:0] m);
        t_operand op;
        op.base  = pick_residue(m);
        op.scale = pick_residue(m);
        case ($urandom_range(0, 7))
            0: op.expo = '0;
            1: op.expo = '1;
            2: op.expo = EXP_BITS'($urandom_range(0, 40));
            3: op.expo = $urandom() >> $urandom_range(0, 31);
            default: op.expo = $urandom();
        endcase
        return op;
    endfunction

    function automatic logic [MOD_BITS-1:0] rand_modulus();
        case ($urandom_range(0, 6))
            0: return MOD_BITS'($urandom_range(2, 100));
            1: return MOD_BITS'($urandom_range(2, 65535));
            2: return MOD_BITS'($urandom()) | (MOD_BITS'(1) << (MOD_BITS - 1));
            3: return MOD_TOP;
            4: return MOD_TOP - MOD_BITS'(1);
            5: return MOD_BITS'($urandom_range(0, 1));
            default: return MOD_BITS'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [MOD_BITS-1:0] got,
                                   input logic [MOD_BITS-1:0] exp_val);
        $display("tb_top: mismatch (%s) got %0d want %0d at cycle %0d",
                 what, got, exp_val, cycle_cnt);
        err_cnt++;
    endtask

    task automatic push_word(input logic [MOD_BITS-1:0] b, input logic [EXP_BITS-1:0] e,
                             input logic [MOD_BITS-1:0] s);
        t_operand op;
        op.base  = b;
        op.expo  = e;
        op.scale = s;
        operand_q.push_back(op);
    endtask

    // Called at a falling edge, returns at a falling edge
    task automatic write_modulus(input logic [MOD_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= MOD_BITS'($urandom());
    endtask

    // Hold until every queued word is taken and every result has come back
    task automatic wait_idle();
        @(posedge i_clk);
        while (operand_q.size() != 0 || in_taken != in_sent || power_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Input driver: bursts of words with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && !(in_ch.valid && in_taken != in_sent)) begin
            if (gap_left != 0) begin
                in_ch.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (operand_q.size() != 0) begin
                cur = operand_q.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.base_value     <= cur.base;
                in_ch.exponent_value <= cur.expo;
                in_ch.scale_factor   <= cur.scale;
                in_sent              <= in_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1200)
                                                              : $urandom_range(0, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: ready follows a per-window mode
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            case ($urandom_range(0, 3))
                2: stall_mode <= RDY_PATTERN;
                3: stall_mode <= RDY_HOLD;
                default: stall_mode <= RDY_OPEN;
            endcase
            stall_pat <= $urandom();
            stall_cnt <= 31;
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            RDY_PATTERN: res_ch.ready <= stall_pat[stall_cnt];
            RDY_HOLD:    res_ch.ready <= 1'b0;
            default:     res_ch.ready <= 1'b1;
        endcase
    end

    // Monitor: check results, predict on accepted words, track the modulus
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch("unexpected result", res_ch.result_value, '0);
                end else begin
                    want = power_q.pop_front();
                    if (res_ch.result_value !== want)
                        report_mismatch("result_value", res_ch.result_value, want);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                cur.base  = in_ch.base_value;
                cur.expo  = in_ch.exponent_value;
                cur.scale = in_ch.scale_factor;
                power_q.push_back(scaled_power(cur, modulus_now));
                in_taken <= in_taken + 1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                modulus_now <= cfg_ch.data;
        end
    end

    // Sequence: reset, directed words, then random phases with a new modulus each
    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.base_value     = '0;
        in_ch.exponent_value = '0;
        in_ch.scale_factor   = '0;
        res_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset modulus: extremes, zero exponent, top exponent bit, base equal to modulus
        push_word('0, '0, '0);
        push_word('0, '0, 1);
        push_word(MOD_TOP, '1, MOD_TOP);
        push_word(MOD_TOP - MOD_BITS'(1), 2, 1);
        push_word(2, 31, 1);
        push_word(3, 5, 7);
        push_word(5, 32'h8000_0000, 1);
        push_word(7, 1, MOD_TOP - MOD_BITS'(1));
        wait_idle();

        // Smallest legal modulus
        write_modulus(2);
        push_word(3, 3, 3);
        push_word(MOD_TOP, '1, MOD_TOP);
        push_word('0, '0, 1);
        wait_idle();

        // Modulus below two gives zero
        write_modulus(0);
        push_word(5, 7, 9);
        push_word(MOD_TOP, '1, MOD_TOP);
        wait_idle();
        write_modulus(1);
        push_word(5, 7, 9);
        push_word('0, '0, '0);
        wait_idle();

        // Small composite modulus with unreduced operands
        write_modulus(12);
        push_word(25, 3, 40);
        push_word(MOD_TOP, 32'h0000_ffff, 11);
        push_word(12, '0, 13);
        wait_idle();

        write_modulus(MOD_TOP);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p != 0) write_modulus(rand_modulus());
            for (int n = 0; n < PHASE_WORDS; n++)
                operand_q.push_back(rand_operand(modulus_now));
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
